// File: rtl/core/nps_pkg.sv
// nps_pkg: types, codes and defaults shared by the note priority stack.
// Used by nps_front, nps_engine and note_priority_stack; depends on nothing.
package nps_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 32;
    localparam int unsigned QUEUE_DEPTH     = 2;

    typedef enum logic {
        OP_PRESS   = 1'b0,
        OP_RELEASE = 1'b1
    } key_op_t;

    typedef enum logic [1:0] {
        MODE_LOWEST  = 2'd0,
        MODE_HIGHEST = 2'd1,
        MODE_LATEST  = 2'd2
    } prio_mode_t;

    typedef enum logic {
        ENG_LOOKUP = 1'b0,
        ENG_APPLY  = 1'b1
    } eng_state_t;

    typedef struct packed {
        key_op_t     operation;
        logic [6:0]  key_number;
        logic [15:0] key_velocity;
    } in_item_t;

    typedef struct packed {
        logic        is_empty;
        logic [5:0]  held_count;
        logic [6:0]  top_note;
        logic [15:0] top_velocity;
        logic        top_first_flag;
        logic [31:0] top_stamp;
        logic [6:0]  runner_note;
        logic [15:0] runner_velocity;
        logic        runner_first_flag;
        logic [31:0] runner_stamp;
    } out_item_t;

    // Command handed from the front queue to the table engine
    typedef struct packed {
        key_op_t     op;
        logic [6:0]  note;
        logic [15:0] velocity;
    } cmd_t;

    typedef struct packed {
        logic [6:0]  note;
        logic [15:0] velocity;
        logic        first;
        logic [31:0] stamp;
    } entry_t;

endpackage

// File: rtl/core/nps_front.sv
// nps_front: input side of the note priority stack; takes key events,
// decodes them into commands and queues them for the table engine. Uses nps_pkg.
module nps_front import nps_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    output logic     cmd_valid,
    input  logic     cmd_ready,
    output cmd_t     cmd
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned LVL_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] level_reg, level_next;
    cmd_t             in_cmd;
    logic             push, pop;

    // Decode: velocity means nothing on a release, so drop it there
    always_comb begin
        in_cmd.op       = s_item.operation;
        in_cmd.note     = s_item.key_number;
        in_cmd.velocity = (s_item.operation == OP_PRESS) ? s_item.key_velocity : 16'd0;
    end

    assign s_ready   = (level_reg != LVL_W'(QUEUE_DEPTH));
    assign cmd_valid = (level_reg != '0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            level_next = level_reg + 1'b1;
        end else if (pop && !push) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

`ifndef NO_ASSERTIONS
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= LVL_W'(QUEUE_DEPTH))
        else $error("front queue level beyond depth");

    a_level_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (level_reg == $past(level_reg) + 1'b1))
        else $error("front queue level lost a transfer");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (level_reg == '0) |-> !pop)
        else $error("command taken from an empty queue");
`endif

endmodule

// File: rtl/core/nps_engine.sv
// nps_engine: note table held as a row of cells with parallel compare and
// shift, its two-step control, the mode register and the result register. Uses nps_pkg.
module nps_engine import nps_pkg::*; #(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  cmd_t       cmd,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_item
);

    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

    entry_t           cell_reg  [TABLE_DEPTH];
    entry_t           cell_next [TABLE_DEPTH];
    entry_t           nb_lower  [TABLE_DEPTH];
    entry_t           nb_upper  [TABLE_DEPTH];
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      stamp_ctr_reg;
    prio_mode_t       mode_reg;
    eng_state_t       state_reg, state_next;

    logic [TABLE_DEPTH-1:0] hit_vec, below_vec, edge_vec;

    cmd_t             lk_cmd_reg;
    logic             lk_found_reg, lk_full_reg;
    logic [IDX_W-1:0] lk_idx_reg, lk_pos_reg;
    logic [IDX_W-1:0] hit_idx, edge_idx, ins_pos;

    logic      lookup_go, apply_go, do_press, do_remove;
    logic      pending_reg, report_load;
    logic      m_valid_reg;
    out_item_t m_item_reg, report;
    entry_t    new_entry, top_entry, run_entry;

    // Per-cell compares against the command at the queue head
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        logic in_use;
        assign in_use     = (CNT_W'(g) < count_reg);
        assign hit_vec[g] = in_use && (cell_reg[g].note == cmd.note);

        always_comb begin
            unique case (mode_reg)
                MODE_LOWEST: below_vec[g] = in_use && (cell_reg[g].note > cmd.note);
                MODE_LATEST: below_vec[g] = in_use && (cell_reg[g].stamp <= stamp_ctr_reg);
                default:     below_vec[g] = in_use && (cell_reg[g].note < cmd.note);
            endcase
        end

        if (g + 1 < TABLE_DEPTH) begin : g_up
            assign edge_vec[g] = below_vec[g] && !below_vec[g + 1];
            assign nb_upper[g] = cell_reg[g + 1];
        end else begin : g_top
            assign edge_vec[g] = below_vec[g];
            assign nb_upper[g] = cell_reg[g];
        end

        if (g > 0) begin : g_dn
            assign nb_lower[g] = cell_reg[g - 1];
        end else begin : g_base
            assign nb_lower[g] = cell_reg[g];
        end
    end

    // The table stays ordered, so the cells that sit below a new note form a
    // run from entry 0; its upper end gives the insert position
    always_comb begin
        hit_idx  = '0;
        edge_idx = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (hit_vec[i]) begin
                hit_idx = hit_idx | IDX_W'(i);
            end
            if (edge_vec[i]) begin
                edge_idx = edge_idx | IDX_W'(i);
            end
        end
        ins_pos = (|edge_vec) ? edge_idx + 1'b1 : '0;
    end

    always_comb begin
        state_next = state_reg;
        cmd_ready  = 1'b0;
        lookup_go  = 1'b0;
        apply_go   = 1'b0;
        unique case (state_reg)
            ENG_LOOKUP: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    lookup_go  = 1'b1;
                    state_next = ENG_APPLY;
                end
            end
            ENG_APPLY: begin
                // hold until the previous result has left the table
                if (!pending_reg) begin
                    apply_go   = 1'b1;
                    state_next = ENG_LOOKUP;
                end
            end
            default: state_next = ENG_LOOKUP;
        endcase
    end

    assign do_press  = (lk_cmd_reg.op == OP_PRESS) && !lk_full_reg && !lk_found_reg;
    assign do_remove = (lk_cmd_reg.op == OP_RELEASE) && lk_found_reg;

    always_comb begin
        new_entry.note     = lk_cmd_reg.note;
        new_entry.velocity = lk_cmd_reg.velocity;
        new_entry.first    = 1'b0;
        new_entry.stamp    = stamp_ctr_reg;
    end

    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            cell_next[i] = cell_reg[i];
            if (apply_go) begin
                if (lk_cmd_reg.op == OP_PRESS) begin
                    if (do_press) begin
                        if (IDX_W'(i) == lk_pos_reg) begin
                            cell_next[i] = new_entry;
                        end else if (IDX_W'(i) > lk_pos_reg && CNT_W'(i) <= count_reg) begin
                            cell_next[i] = nb_lower[i];
                        end
                        if (i == 0) begin
                            cell_next[i].first = (count_reg == '0);
                        end
                    end
                end else begin
                    // clear entry 0's flag first, then close the gap
                    if (do_remove && IDX_W'(i) >= lk_idx_reg
                        && (CNT_W'(i) + CNT_W'(1)) < count_reg) begin
                        cell_next[i] = nb_upper[i];
                    end else if (i == 0) begin
                        cell_next[i].first = 1'b0;
                    end
                end
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cfg_wr_en) begin
            count_next = '0;
        end else if (apply_go && do_press) begin
            count_next = count_reg + 1'b1;
        end else if (apply_go && do_remove) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Result from the updated table: top is entry count-1, runner count-2
    always_comb begin
        top_entry = '0;
        run_entry = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if ((count_reg != '0) ? (CNT_W'(i) == count_reg - 1'b1) : (i == 0)) begin
                top_entry = top_entry | cell_reg[i];
            end
            if ((count_reg >= CNT_W'(2)) ? (CNT_W'(i) == count_reg - CNT_W'(2)) : (i == 0)) begin
                run_entry = run_entry | cell_reg[i];
            end
        end
        report.is_empty          = (count_reg == '0);
        report.held_count        = 6'(count_reg);
        report.top_note          = top_entry.note;
        report.top_velocity      = top_entry.velocity;
        report.top_first_flag    = top_entry.first;
        report.top_stamp         = top_entry.stamp;
        report.runner_note       = run_entry.note;
        report.runner_velocity   = run_entry.velocity;
        report.runner_first_flag = run_entry.first;
        report.runner_stamp      = run_entry.stamp;
    end

    assign report_load = pending_reg && (!m_valid_reg || m_ready);
    assign m_valid     = m_valid_reg;
    assign m_item      = m_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ENG_LOOKUP;
            count_reg     <= '0;
            stamp_ctr_reg <= '0;
            mode_reg      <= MODE_HIGHEST;
            pending_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                cell_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                cell_reg[i] <= cell_next[i];
            end
            if (apply_go && do_press) begin
                stamp_ctr_reg <= stamp_ctr_reg + 1'b1;
            end
            if (cfg_wr_en) begin
                // the unused code falls back to highest note
                mode_reg <= (cfg_wr_data == 2'd3) ? MODE_HIGHEST : prio_mode_t'(cfg_wr_data);
            end
            if (apply_go) begin
                pending_reg <= 1'b1;
            end else if (report_load) begin
                pending_reg <= 1'b0;
            end
            if (report_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (lookup_go) begin
            lk_cmd_reg   <= cmd;
            lk_found_reg <= |hit_vec;
            lk_full_reg  <= (count_reg == CNT_W'(TABLE_DEPTH));
            lk_idx_reg   <= hit_idx;
            lk_pos_reg   <= ins_pos;
        end
        if (report_load) begin
            m_item_reg <= report;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("held count beyond table depth");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !cfg_wr_en |=> (count_reg == $past(count_reg)
                        || count_reg == $past(count_reg) + CNT_W'(1)
                        || count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("held count moved by more than one");

    a_mode_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> (count_reg == '0))
        else $error("mode write did not empty the table");

    a_apply_reports: assert property (@(posedge aclk) disable iff (!aresetn)
        apply_go |=> pending_reg)
        else $error("applied command left no result pending");

    a_hit_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_valid |-> $onehot0(hit_vec))
        else $error("note held in more than one entry");
`endif

endmodule

// File: rtl/core/note_priority_stack.sv
// note_priority_stack: top level of the keyboard note priority table.
// Instantiates nps_front and nps_engine; uses nps_pkg.
//
//  Channel   Ports                          Moves
//  input     s_valid / s_ready / s_item     one key press or release per transfer
//  result    m_valid / m_ready / m_item     one table report per input transfer
//  config    cfg_wr_en / cfg_wr_data        priority mode, no handshake
//
// An event passes the compare step, then the update step, which waits while
// the previous report is pending; no new event is taken before the update.
// The report enters the result register once that is free. The two-entry
// front queue takes events until full while the engine or result side stalls.
// Reset is synchronous and, like a mode write, empties the table at once.
module note_priority_stack import nps_pkg::*; #(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_item,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_item
);

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    nps_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    nps_engine #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

endmodule
